// ===== rtl/core/tdoa_pkg.sv =====
// Shared types, widths and constants for the far-field TDOA lookup unit.
package tdoa_pkg;

  // Default configuration of the top level
  localparam int MAX_MICS_DEF   = 8;
  localparam int INDEX_BITS_DEF = 12;

  // Field widths fixed by the item format
  localparam int COORD_W     = 16;
  localparam int SLOT_W      = 3;
  localparam int OPCODE_W    = 2;
  localparam int MIC_COUNT_W = 4;
  localparam int SCALE_W     = 20;
  localparam int PAIR_IDX_W  = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int S_TDATA_W   = 56;

  // Arithmetic widths: Q4.12 difference, Q.26 dot, Q.34 scaled product
  localparam int DIFF_W    = COORD_W + 1;
  localparam int TERM_W    = DIFF_W + COORD_W;
  localparam int DOT_W     = TERM_W + 2;
  localparam int LO_SPLIT  = 18;
  localparam int LO_W      = LO_SPLIT + SCALE_W;
  localparam int HI_W      = DOT_W - LO_SPLIT + SCALE_W + 1;
  localparam int PROD_W    = DOT_W + SCALE_W;
  localparam int RND_SHIFT = 34;
  localparam int R_W       = PROD_W - RND_SHIFT;
  localparam int D_W       = R_W + 2;

  // Register reset values
  localparam int MIC_COUNT_RST     = 2;
  localparam int DELAY_SCALE_RST   = 47770;
  localparam int CENTER_OFFSET_RST = 1024;
  localparam int MAX_INDEX_RST     = 2047;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POINT = 2'd2
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIC_COUNT     = 2'd0,
    REG_DELAY_SCALE   = 2'd1,
    REG_CENTER_OFFSET = 2'd2,
    REG_MAX_INDEX     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } mic_pos_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // write a mic slot from the input item
    logic start;  // clear running bounds
    logic point;  // latch the direction point
    logic issue;  // push one pair into the pipeline
    logic last;   // issued pair is the final one of the point
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic adv;    // pipeline moves this cycle
    logic busy;   // some pair still in flight before the output register
  } dp_stat_t;

endpackage

// ===== rtl/core/tdoa_ctrl.sv =====
// Sequencer for the TDOA unit: item decode and the i<j pair walk.
module tdoa_ctrl import tdoa_pkg::*; #(
  parameter int MAX_MICS = MAX_MICS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_valid,
  output logic                                 s_ready,
  input  opcode_t                              opcode,
  input  logic [MIC_COUNT_W-1:0]               mic_count,
  input  dp_stat_t                             stat,
  output dp_cmd_t                              cmd,
  output logic [$clog2(MAX_MICS)-1:0]          mic_a,
  output logic [$clog2(MAX_MICS)-1:0]          mic_b,
  output logic [((MAX_MICS * (MAX_MICS - 1) / 2) > 1 ?
                 $clog2(MAX_MICS * (MAX_MICS - 1) / 2) : 1)-1:0] pair
);

  localparam int MIC_AW = $clog2(MAX_MICS);
  localparam int MIC_CW = $clog2(MAX_MICS + 1);
  localparam int PAIRS  = MAX_MICS * (MAX_MICS - 1) / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  ctrl_state_t       state, state_next;
  logic [MIC_AW-1:0] i_idx, i_idx_next;
  logic [MIC_AW-1:0] j_idx, j_idx_next;
  logic [PAIR_W-1:0] pair_cnt, pair_cnt_next;
  logic [MIC_CW-1:0] n_eff;
  logic              last_pair;
  logic              row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    i_idx    <= i_idx_next;
    j_idx    <= j_idx_next;
    pair_cnt <= pair_cnt_next;
  end

  always_comb begin
    // counts above the array size use the whole array
    n_eff     = (int'(mic_count) > MAX_MICS) ? MIC_CW'(MAX_MICS) : MIC_CW'(mic_count);
    row_end   = (j_idx == MIC_AW'(n_eff - MIC_CW'(1)));
    last_pair = row_end && (i_idx == MIC_AW'(n_eff - MIC_CW'(2)));

    state_next    = state;
    i_idx_next    = i_idx;
    j_idx_next    = j_idx;
    pair_cnt_next = pair_cnt;
    cmd           = '0;
    s_ready       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          unique case (opcode)
            OP_LOAD:  cmd.load  = 1'b1;
            OP_START: cmd.start = 1'b1;
            OP_POINT: begin
              cmd.point = 1'b1;
              if (n_eff >= MIC_CW'(2)) begin
                state_next    = ST_ISSUE;
                i_idx_next    = '0;
                j_idx_next    = MIC_AW'(1);
                pair_cnt_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (stat.adv) begin
          cmd.issue     = 1'b1;
          cmd.last      = last_pair;
          pair_cnt_next = PAIR_W'(pair_cnt + 1'b1);
          if (last_pair) begin
            state_next = ST_DRAIN;
          end else if (row_end) begin
            i_idx_next = MIC_AW'(i_idx + 1'b1);
            j_idx_next = MIC_AW'(i_idx + 2'd2);
          end else begin
            j_idx_next = MIC_AW'(j_idx + 1'b1);
          end
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign mic_a = i_idx;
  assign mic_b = j_idx;
  assign pair  = pair_cnt;

  // a pair enters only on a cycle the pipeline moves
  a_issue_on_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> stat.adv)
    else $error("pair issued during output stall");

  // nothing may still be in flight once a new item can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !stat.busy)
    else $error("pipeline busy while accepting items");

  // final pair hands over to the drain wait
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.last) |=> (state == ST_DRAIN))
    else $error("final pair did not enter drain");

  // pairs always come from distinct microphones
  a_distinct_mics: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (mic_a < mic_b))
    else $error("pair with i >= j issued");

endmodule

// ===== rtl/core/tdoa_dp.sv =====
// Datapath for the TDOA unit: mic store, delay pipeline, bound memory, output register.
module tdoa_dp import tdoa_pkg::*; #(
  parameter int MAX_MICS   = MAX_MICS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dp_cmd_t                              cmd,
  input  logic [$clog2(MAX_MICS)-1:0]          mic_a,
  input  logic [$clog2(MAX_MICS)-1:0]          mic_b,
  input  logic [((MAX_MICS * (MAX_MICS - 1) / 2) > 1 ?
                 $clog2(MAX_MICS * (MAX_MICS - 1) / 2) : 1)-1:0] pair,
  input  logic [SLOT_W-1:0]                    slot,
  input  mic_pos_t                             coord,
  input  logic [SCALE_W-1:0]                   delay_scale,
  input  logic [INDEX_BITS-1:0]                center_offset,
  input  logic [INDEX_BITS-1:0]                max_index,
  output dp_stat_t                             stat,
  output logic                                 m_valid,
  input  logic                                 m_ready,
  output logic [PAIR_IDX_W-1:0]                out_pair,
  output logic [INDEX_BITS-1:0]                out_delay,
  output logic [INDEX_BITS-1:0]                out_min,
  output logic [INDEX_BITS-1:0]                out_max,
  output logic                                 out_clip,
  output logic                                 out_last
);

  localparam int MIC_AW = $clog2(MAX_MICS);
  localparam int PAIRS  = MAX_MICS * (MAX_MICS - 1) / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int NSTG   = 7;

  // storage
  mic_pos_t                    mic_mem [MAX_MICS];
  logic [2*INDEX_BITS-1:0]     bound_mem [PAIRS];
  logic [PAIRS-1:0]            bvalid;
  logic [INDEX_BITS-1:0]       clear_low;
  mic_pos_t                    pt;

  // stage control
  logic                        adv;
  logic [NSTG:1]               v;
  logic [PAIR_W-1:0]           tag_pair [1:NSTG];
  logic                        tag_last [1:NSTG];

  // stage payload
  mic_pos_t                    ma, mb;
  logic signed [DIFF_W-1:0]    dx, dy, dz;
  logic signed [TERM_W-1:0]    px, py, pz;
  logic signed [DOT_W-1:0]     dot;
  logic        [LO_W-1:0]      lo;
  logic signed [HI_W-1:0]      hi;
  logic signed [PROD_W-1:0]    prod;
  logic        [PROD_W-1:0]    mag;
  logic                        neg;
  logic        [PROD_W-1:0]    rsum;
  logic        [R_W-1:0]       rnd;
  logic signed [D_W-1:0]       rmag, rdel, d;
  logic [2*INDEX_BITS-1:0]     brd;

  // final stage
  logic [INDEX_BITS-1:0]       idx;
  logic                        clip;
  logic [INDEX_BITS-1:0]       low_in, high_in, low_new, high_new;

  assign adv       = !m_valid || m_ready;
  assign stat.adv  = adv;
  assign stat.busy = |v;

  always_ff @(posedge clk) begin
    if (cmd.load && (int'(slot) < MAX_MICS)) begin
      mic_mem[MIC_AW'(slot)] <= coord;
    end
    if (cmd.point) begin
      pt <= coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      m_valid   <= 1'b0;
      bvalid    <= '0;
      clear_low <= INDEX_BITS'(MAX_INDEX_RST);
    end else begin
      if (adv) begin
        v       <= {v[NSTG-1:1], cmd.issue};
        m_valid <= v[NSTG];
      end
      if (cmd.start) begin
        bvalid    <= '0;
        clear_low <= max_index;
      end else if (adv && v[NSTG]) begin
        bvalid[tag_pair[NSTG]] <= 1'b1;
      end
    end
  end

  // tags follow the pair down the pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      tag_pair[1] <= pair;
      tag_last[1] <= cmd.last;
      for (int k = 2; k <= NSTG; k++) begin
        tag_pair[k] <= tag_pair[k-1];
        tag_last[k] <= tag_last[k-1];
      end
    end
  end

  always_comb begin
    dx = DIFF_W'(ma.x) - DIFF_W'(mb.x);
    dy = DIFF_W'(ma.y) - DIFF_W'(mb.y);
    dz = DIFF_W'(ma.z) - DIFF_W'(mb.z);
    rsum = mag + (PROD_W'(1) << (RND_SHIFT - 1));
    rnd  = rsum[PROD_W-1:RND_SHIFT];
    rmag = $signed(D_W'(rnd));
    rdel = neg ? -rmag : rmag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // 1: mic read
      ma <= mic_mem[mic_a];
      mb <= mic_mem[mic_b];
      // 2: differences times point
      px <= dx * pt.x;
      py <= dy * pt.y;
      pz <= dz * pt.z;
      // 3: dot product
      dot <= DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
      // 4: split scale multiply
      lo <= LO_W'(dot[LO_SPLIT-1:0]) * LO_W'(delay_scale);
      hi <= $signed(dot[DOT_W-1:LO_SPLIT]) * $signed({1'b0, delay_scale});
      // 5: recombine partial products
      prod <= (PROD_W'(hi) <<< LO_SPLIT) + $signed(PROD_W'(lo));
      // 6: sign and magnitude; delay is minus the product
      neg <= (prod > 0);
      mag <= prod[PROD_W-1] ? $unsigned(-prod) : $unsigned(prod);
      // 7: round half away from zero, add centre; fetch bounds
      d   <= rdel + $signed(D_W'(center_offset));
      brd <= bound_mem[tag_pair[NSTG-1]];
    end
  end

  always_comb begin
    if (d < 0) begin
      idx  = '0;
      clip = 1'b1;
    end else if (d > $signed(D_W'(max_index))) begin
      idx  = max_index;
      clip = 1'b1;
    end else begin
      idx  = d[INDEX_BITS-1:0];
      clip = 1'b0;
    end
    low_in   = bvalid[tag_pair[NSTG]] ? brd[INDEX_BITS-1:0] : clear_low;
    high_in  = bvalid[tag_pair[NSTG]] ? brd[2*INDEX_BITS-1:INDEX_BITS] : '0;
    low_new  = (idx < low_in)  ? idx : low_in;
    high_new = (idx > high_in) ? idx : high_in;
  end

  always_ff @(posedge clk) begin
    if (adv && v[NSTG]) begin
      bound_mem[tag_pair[NSTG]] <= {high_new, low_new};
      out_pair  <= PAIR_IDX_W'(tag_pair[NSTG]);
      out_delay <= idx;
      out_min   <= low_new;
      out_max   <= high_new;
      out_clip  <= clip;
      out_last  <= tag_last[NSTG];
    end
  end

endmodule

// ===== rtl/core/tdoa_table_with_pair_bounds_unit.sv =====
// Top level of the far-field TDOA lookup with per-pair delay bounds.
// Pair results of a point follow one a cycle while the output does not stall.
// A point with P pairs (P = n(n-1)/2, 28 at eight mics) holds off the next item until the
//   seven-stage delay pipeline has drained (bounds read-modify-write).
// Load and start items give no result; output stalls freeze the pipeline.
// Reset: registers to 2, 47770, 1024, 2047; bounds read as 2047 / zero; mic slots unset.
module tdoa_table_with_pair_bounds_unit import tdoa_pkg::*; #(
  parameter int MAX_MICS   = MAX_MICS_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // input items
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [S_TDATA_W-1:0]     s_tdata,   // mic_index, coord_x, coord_y, coord_z, zero pad
  input  logic [OPCODE_W-1:0]      s_tuser,   // opcode
  // pair results
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [((PAIR_IDX_W + 3 * INDEX_BITS + 7) / 8) * 8 - 1:0] m_tdata,
                                              // pair_index, delay_index, pair_min, pair_max, pad
  output logic                     m_tuser,   // clipped
  output logic                     m_tlast,   // last pair of the point
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int M_TDATA_W = ((PAIR_IDX_W + 3 * INDEX_BITS + 7) / 8) * 8;
  localparam int MIC_AW    = $clog2(MAX_MICS);
  localparam int PAIRS     = MAX_MICS * (MAX_MICS - 1) / 2;
  localparam int PAIR_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  // configuration registers
  logic [MIC_COUNT_W-1:0] mic_count;
  logic [SCALE_W-1:0]     delay_scale;
  logic [INDEX_BITS-1:0]  center_offset;
  logic [INDEX_BITS-1:0]  max_index;

  // input item fields
  logic [SLOT_W-1:0]      mic_index;
  mic_pos_t               coord;
  opcode_t                opcode;

  // controller / datapath link
  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [MIC_AW-1:0]      mic_a, mic_b;
  logic [PAIR_W-1:0]      pair;

  // result fields
  logic [PAIR_IDX_W-1:0]  out_pair;
  logic [INDEX_BITS-1:0]  out_delay, out_min, out_max;

  // Writes must land only while the block is idle; the block does not enforce this. The port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mic_count     <= MIC_COUNT_W'(MIC_COUNT_RST);
      delay_scale   <= SCALE_W'(DELAY_SCALE_RST);
      center_offset <= INDEX_BITS'(CENTER_OFFSET_RST);
      max_index     <= INDEX_BITS'(MAX_INDEX_RST);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIC_COUNT:     mic_count     <= cfg_data[MIC_COUNT_W-1:0];
        REG_DELAY_SCALE:   delay_scale   <= cfg_data[SCALE_W-1:0];
        REG_CENTER_OFFSET: center_offset <= cfg_data[INDEX_BITS-1:0];
        REG_MAX_INDEX:     max_index     <= cfg_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // unpack the input transfer
  assign mic_index = s_tdata[SLOT_W-1:0];
  assign coord.x   = s_tdata[SLOT_W +: COORD_W];
  assign coord.y   = s_tdata[SLOT_W + COORD_W +: COORD_W];
  assign coord.z   = s_tdata[SLOT_W + 2 * COORD_W +: COORD_W];
  assign opcode    = opcode_t'(s_tuser);

  // Controller: takes one item at a time, walks pairs i<j, waits for the pipe to empty.
  tdoa_ctrl #(
    .MAX_MICS (MAX_MICS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .opcode    (opcode),
    .mic_count (mic_count),
    .stat      (stat),
    .cmd       (cmd),
    .mic_a     (mic_a),
    .mic_b     (mic_b),
    .pair      (pair)
  );

  // Datapath: mic slots, dot/scale/round pipeline, bound memory and the output register.
  tdoa_dp #(
    .MAX_MICS   (MAX_MICS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mic_a         (mic_a),
    .mic_b         (mic_b),
    .pair          (pair),
    .slot          (mic_index),
    .coord         (coord),
    .delay_scale   (delay_scale),
    .center_offset (center_offset),
    .max_index     (max_index),
    .stat          (stat),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .out_pair      (out_pair),
    .out_delay     (out_delay),
    .out_min       (out_min),
    .out_max       (out_max),
    .out_clip      (m_tuser),
    .out_last      (m_tlast)
  );

  // pack the result transfer, lowest field first
  assign m_tdata = M_TDATA_W'({out_max, out_min, out_delay, out_pair});

endmodule
